// ===== rtl/core/skht_pkg.sv =====
`timescale 1ns / 1ps

package skht_pkg;

  localparam int TABLE_SIZE_DEF    = 256;
  localparam int MAX_KEY_CHARS_DEF = 49;

  localparam int CFG_W    = 9;
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int HASH_W   = 32;

  localparam logic [CFG_W-1:0]  CFG_SLOTS_RESET = 9'd256;
  localparam logic [HASH_W-1:0] HASH_MULT       = 32'd31;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_ABSENT_EMPTY = 3'd1,
    STAT_ABSENT_SWEEP = 3'd2,
    STAT_FULL         = 3'd3,
    STAT_TOO_LONG     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_META,
    S_CMP,
    S_COPY
  } state_t;

  typedef struct packed {
    logic              go;
    logic [HASH_W-1:0] dividend;
  } mod_req_t;

endpackage

// ===== rtl/core/skht_ram.sv =====
`timescale 1ns / 1ps

module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/skht_mod.sv =====
`timescale 1ns / 1ps

module skht_mod #(
  parameter int DIV_W = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  skht_pkg::mod_req_t req,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   remainder
);

  import skht_pkg::*;

  localparam int STEP_W = $clog2(HASH_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    dvs_ext;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_step;

  always_comb begin
    shifted  = {rem_r, dvd_r[HASH_W-1]};
    dvs_ext  = {1'b0, dvs_r};
    trial    = shifted - dvs_ext;
    rem_step = (shifted >= dvs_ext) ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];

    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;

    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = req.dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = rem_step;
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(HASH_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/string_key_hash_table_top.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                          | Transfer
// ---------+------------------------------------------------+--------------------------
// input    | start, busy, in_key_char, in_key_last,         | start high and busy low
//          | in_mode, in_value                              |
// result   | out_valid, out_status, out_found_value         | out_valid high, one cycle
// config   | cfg_valid, cfg_ready, cfg_table_slots          | cfg_valid and cfg_ready
//
// A key character that is not the last leaves busy low. A last character
// starts the bit-serial remainder unit, one dividend bit per step; then each
// probed slot passes through S_READ and S_META, plus an S_CMP step per
// compared character of an equal-length key, and an insert copies the key
// into its slot in S_COPY. A too-long key returns its result in the next
// cycle. After reset a clearing pass empties the slot table with busy high.
// Results cannot be stalled by the receiver.

module string_key_hash_table_top #(
  parameter int TABLE_SIZE    = skht_pkg::TABLE_SIZE_DEF,
  parameter int MAX_KEY_CHARS = skht_pkg::MAX_KEY_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [skht_pkg::CHAR_W-1:0]         in_key_char,
  input  logic                                in_key_last,
  input  logic                                in_mode,
  input  logic signed [skht_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  output logic [skht_pkg::STATUS_W-1:0]       out_status,
  output logic signed [skht_pkg::VALUE_W-1:0] out_found_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skht_pkg::CFG_W-1:0]          cfg_table_slots
);

  import skht_pkg::*;

  localparam int SW    = $clog2(TABLE_SIZE);
  localparam int NW    = $clog2(TABLE_SIZE + 1);
  localparam int CMP_W = (NW > CFG_W) ? NW : CFG_W;
  localparam int KW    = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam int LW    = $clog2(MAX_KEY_CHARS + 1);
  localparam int META_W = LW + 1;

  state_t                   state_r, state_nxt;
  logic [HASH_W-1:0]        hash_r, hash_nxt;
  logic [LW-1:0]            len_r, len_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     mode_r, mode_nxt;
  logic [VALUE_W-1:0]       value_r, value_nxt;
  logic [SW-1:0]            idx_r, idx_nxt;
  logic [NW-1:0]            cnt_r, cnt_nxt;
  logic [LW-1:0]            j_r, j_nxt;
  logic [SW-1:0]            clr_r, clr_nxt;
  logic [CFG_W-1:0]         cfg_r, cfg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]       out_value_r, out_value_nxt;

  logic [CMP_W-1:0]         cfg_ext;
  logic [CMP_W-1:0]         n_cmp;
  logic [NW-1:0]            n_eff;
  logic [HASH_W-1:0]        hash_upd;
  logic                     len_room;
  logic [LW-1:0]            j_inc;
  logic [LW-1:0]            j_dec;
  logic [NW-1:0]            cnt_inc;
  logic [NW-1:0]            idx_inc;
  logic                     finish;
  logic                     advance;
  logic [STATUS_W-1:0]      fin_status;
  logic [VALUE_W-1:0]       fin_value;

  mod_req_t                 mod_req;
  logic                     mod_done;
  logic [NW-1:0]            mod_rem;

  logic                     kb_wr_en, kb_rd_en;
  logic [KW-1:0]            kb_wr_addr, kb_rd_addr;
  logic [CHAR_W-1:0]        kb_rd_data;

  logic                     sc_wr_en, sc_rd_en;
  logic [SW+KW-1:0]         sc_wr_addr, sc_rd_addr;
  logic [CHAR_W-1:0]        sc_wr_data, sc_rd_data;

  logic                     meta_wr_en, meta_rd_en;
  logic [SW-1:0]            meta_wr_addr;
  logic [META_W-1:0]        meta_wr_data, meta_rd_data;

  logic                     val_wr_en;
  logic [VALUE_W-1:0]       val_rd_data;

  always_comb begin
    cfg_ext  = CMP_W'(cfg_r);
    n_cmp    = (cfg_ext == '0) ? CMP_W'(1) :
               ((cfg_ext > CMP_W'(TABLE_SIZE)) ? CMP_W'(TABLE_SIZE) : cfg_ext);
    n_eff    = n_cmp[NW-1:0];
    hash_upd = hash_r * HASH_MULT + HASH_W'(in_key_char);
    len_room = len_r < LW'(MAX_KEY_CHARS);
    j_inc    = j_r + LW'(1);
    j_dec    = j_r - LW'(1);
    cnt_inc  = cnt_r + NW'(1);
    idx_inc  = NW'(idx_r) + NW'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    len_nxt        = len_r;
    ovf_nxt        = ovf_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    j_nxt          = j_r;
    clr_nxt        = clr_r;
    cfg_nxt        = cfg_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;

    finish     = 1'b0;
    advance    = 1'b0;
    fin_status = STAT_OK;
    fin_value  = '0;

    mod_req.go       = 1'b0;
    mod_req.dividend = hash_upd;

    kb_wr_en   = 1'b0;
    kb_wr_addr = len_r[KW-1:0];
    kb_rd_en   = 1'b0;
    kb_rd_addr = '0;
    sc_wr_en   = 1'b0;
    sc_wr_addr = {idx_r, j_dec[KW-1:0]};
    sc_wr_data = kb_rd_data;
    sc_rd_en   = 1'b0;
    sc_rd_addr = {idx_r, KW'(0)};
    meta_wr_en   = 1'b0;
    meta_wr_addr = idx_r;
    meta_wr_data = {1'b1, len_r};
    meta_rd_en   = 1'b0;
    val_wr_en    = 1'b0;

    if (cfg_valid) begin
      cfg_nxt = cfg_table_slots;
    end

    case (state_r)
      S_CLEAR: begin
        meta_wr_en   = 1'b1;
        meta_wr_addr = clr_r;
        meta_wr_data = '0;
        if (clr_r == SW'(TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + SW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          hash_nxt = hash_upd;
          if (len_room) begin
            kb_wr_en = 1'b1;
            len_nxt  = len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_key_last) begin
            hash_nxt = '0;
            if (ovf_r || !len_room) begin
              finish     = 1'b1;
              fin_status = STAT_TOO_LONG;
            end else begin
              mode_nxt   = in_mode;
              value_nxt  = in_value;
              mod_req.go = 1'b1;
              state_nxt  = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem[SW-1:0];
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        meta_rd_en = 1'b1;
        state_nxt  = S_META;
      end
      S_META: begin
        if (!meta_rd_data[LW]) begin
          if (mode_r) begin
            finish     = 1'b1;
            fin_status = STAT_ABSENT_EMPTY;
          end else begin
            j_nxt     = '0;
            state_nxt = S_COPY;
          end
        end else if (meta_rd_data[LW-1:0] == len_r) begin
          kb_rd_en   = 1'b1;
          sc_rd_en   = 1'b1;
          j_nxt      = '0;
          state_nxt  = S_CMP;
        end else begin
          advance = 1'b1;
        end
      end
      S_CMP: begin
        if (kb_rd_data != sc_rd_data) begin
          advance = 1'b1;
        end else if (j_inc == len_r) begin
          if (mode_r) begin
            finish     = 1'b1;
            fin_status = STAT_OK;
            fin_value  = val_rd_data;
          end else begin
            j_nxt     = '0;
            state_nxt = S_COPY;
          end
        end else begin
          kb_rd_en   = 1'b1;
          kb_rd_addr = j_inc[KW-1:0];
          sc_rd_en   = 1'b1;
          sc_rd_addr = {idx_r, j_inc[KW-1:0]};
          j_nxt      = j_inc;
        end
      end
      S_COPY: begin
        if (j_r != '0) begin
          sc_wr_en = 1'b1;
        end
        if (j_r == len_r) begin
          meta_wr_en = 1'b1;
          val_wr_en  = 1'b1;
          finish     = 1'b1;
          fin_status = STAT_OK;
        end else begin
          kb_rd_en   = 1'b1;
          kb_rd_addr = j_r[KW-1:0];
          j_nxt      = j_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (advance) begin
      if (cnt_inc == n_eff) begin
        finish     = 1'b1;
        fin_status = mode_r ? STAT_ABSENT_SWEEP : STAT_FULL;
      end else begin
        cnt_nxt   = cnt_inc;
        idx_nxt   = (idx_inc == n_eff) ? '0 : idx_inc[SW-1:0];
        state_nxt = S_READ;
      end
    end

    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_value_nxt  = fin_value;
      len_nxt        = '0;
      ovf_nxt        = 1'b0;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hash_r      <= '0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      cfg_r       <= CFG_SLOTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hash_r      <= hash_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    j_r          <= j_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  skht_mod #(
    .DIV_W(NW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mod_req),
    .divisor  (n_eff),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  skht_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_KEY_CHARS)
  ) u_key_buf (
    .clk    (clk),
    .wr_en  (kb_wr_en),
    .wr_addr(kb_wr_addr),
    .wr_data(in_key_char),
    .rd_en  (kb_rd_en),
    .rd_addr(kb_rd_addr),
    .rd_data(kb_rd_data)
  );

  skht_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(TABLE_SIZE * (2 ** KW))
  ) u_slot_chars (
    .clk    (clk),
    .wr_en  (sc_wr_en),
    .wr_addr(sc_wr_addr),
    .wr_data(sc_wr_data),
    .rd_en  (sc_rd_en),
    .rd_addr(sc_rd_addr),
    .rd_data(sc_rd_data)
  );

  skht_ram #(
    .WIDTH(META_W),
    .DEPTH(TABLE_SIZE)
  ) u_slot_meta (
    .clk    (clk),
    .wr_en  (meta_wr_en),
    .wr_addr(meta_wr_addr),
    .wr_data(meta_wr_data),
    .rd_en  (meta_rd_en),
    .rd_addr(idx_r),
    .rd_data(meta_rd_data)
  );

  skht_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_SIZE)
  ) u_slot_value (
    .clk    (clk),
    .wr_en  (val_wr_en),
    .wr_addr(idx_r),
    .wr_data(value_r),
    .rd_en  (meta_rd_en),
    .rd_addr(idx_r),
    .rd_data(val_rd_data)
  );

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule
